FILE: src/scfb_pkg.sv
package scfb_pkg;

    localparam logic [7:0] OP_PINS    = 8'h01;
    localparam logic [7:0] OP_SERVO_A = 8'h07;
    localparam logic [7:0] OP_SERVO_B = 8'h08;

    localparam logic [7:0] CFG_SPEED = 8'd0;
    localparam logic [7:0] CFG_A_ID  = 8'd1;
    localparam logic [7:0] CFG_B_ID  = 8'd2;

    localparam logic [1:0] KIND_PINS  = 2'd0;
    localparam logic [1:0] KIND_SERVO = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    localparam int unsigned FRAME_LEN = 21;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  pins;
        logic [7:0]  id;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [7:0]  pos_sum;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

FILE: src/scfb_front.sv
module scfb_front
    import scfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [15:0] r_speed;
    logic [7:0]  r_a_id;
    logic [7:0]  r_b_id;
    logic [6:0]  r_pins;

    logic [15:0] offs;
    logic [15:0] angle;
    logic [7:0]  id;

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    // (128 - data) * 6, kept modulo 2^16
    assign offs  = 16'd128 - {8'd0, i_data_byte};
    assign angle = (offs << 2) + (offs << 1);
    assign id    = (i_opcode == OP_SERVO_A) ? r_a_id : r_b_id;

    always_comb begin
        o_cmd.pins    = r_pins;
        o_cmd.id      = id;
        o_cmd.angle   = angle;
        o_cmd.speed   = r_speed;
        // XOR of id, 00, 1E, 04, 01 and the four data bytes
        o_cmd.pos_sum = id ^ 8'h1B ^ angle[7:0] ^ angle[15:8]
                        ^ r_speed[7:0] ^ r_speed[15:8];
        if (i_opcode == OP_PINS) begin
            o_cmd.kind = KIND_PINS;
            o_cmd.pins = i_data_byte[6:0];
        end else if (i_opcode == OP_SERVO_A || i_opcode == OP_SERVO_B) begin
            o_cmd.kind = KIND_SERVO;
        end else begin
            o_cmd.kind = KIND_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= 16'd1;
            r_a_id  <= 8'd1;
            r_b_id  <= 8'd2;
            r_pins  <= 7'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPEED: r_speed <= i_cfg_data;
                    CFG_A_ID:  r_a_id  <= i_cfg_data[7:0];
                    CFG_B_ID:  r_b_id  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (o_push && i_opcode == OP_PINS) begin
                r_pins <= i_data_byte[6:0];
            end
        end
    end

endmodule

FILE: src/scfb_queue.sv
module scfb_queue
    import scfb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/scfb_back.sv
module scfb_back
    import scfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_valid,
    output logic [6:0] o_pin_levels,
    output logic       o_bad_command,
    output logic       o_last
);

    localparam logic [4:0] LAST_IDX = 5'(FRAME_LEN - 1);

    logic [4:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_txv;
    logic [6:0] r_pins;
    logic       r_bad;
    logic       r_last;

    logic       advance;
    logic       servo;
    logic       fin;
    logic [7:0] frame_byte;

    assign advance = !r_valid || i_ready;
    assign servo   = (i_head.kind == KIND_SERVO);
    assign fin     = !servo || (r_idx == LAST_IDX);
    assign o_pop   = advance && !i_q_status.empty && fin;

    always_comb begin
        case (r_idx)
            5'd0, 5'd9:              frame_byte = 8'hFA;
            5'd1, 5'd10:             frame_byte = 8'hAF;
            5'd2, 5'd11:             frame_byte = i_head.id;
            5'd3, 5'd12:             frame_byte = 8'h00;
            5'd4:                    frame_byte = 8'h24;
            5'd5, 5'd6, 5'd7, 5'd15: frame_byte = 8'h01;
            5'd8:                    frame_byte = i_head.id ^ 8'h25; // torque-on sum
            5'd13:                   frame_byte = 8'h1E;
            5'd14:                   frame_byte = 8'h04;
            5'd16:                   frame_byte = i_head.angle[7:0];
            5'd17:                   frame_byte = i_head.angle[15:8];
            5'd18:                   frame_byte = i_head.speed[7:0];
            5'd19:                   frame_byte = i_head.speed[15:8];
            5'd20:                   frame_byte = i_head.pos_sum;
            default:                 frame_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= !i_q_status.empty;
            if (!i_q_status.empty) begin
                r_idx <= fin ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !i_q_status.empty) begin
            r_byte <= servo ? frame_byte : 8'h00;
            r_txv  <= servo;
            r_pins <= i_head.pins;
            r_bad  <= (i_head.kind == KIND_BAD);
            r_last <= fin;
        end
    end

    assign o_valid       = r_valid;
    assign o_tx_byte     = r_byte;
    assign o_tx_valid    = r_txv;
    assign o_pin_levels  = r_pins;
    assign o_bad_command = r_bad;
    assign o_last        = r_last;

endmodule

FILE: src/servo_command_frame_bridge_core.sv
// The first result of a command passes through the command queue and the output register.
// A servo command gives 21 bytes, one per cycle from the output register while the
// output is not stalled; pin and unknown commands give a single result.
// A short command queue lets input transfers continue while the output stalls.
// Reset (synchronous, active low) empties the queue and output, clears the pins
// and returns speed, servo A id and servo B id to 1, 1 and 2.
module servo_command_frame_bridge_core
    import scfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic [6:0]  o_pin_levels,
    output logic        o_bad_command,
    output logic        o_last
);

    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    scfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    scfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    scfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_cmd),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tx_byte     (o_tx_byte),
        .o_tx_valid    (o_tx_valid),
        .o_pin_levels  (o_pin_levels),
        .o_bad_command (o_bad_command),
        .o_last        (o_last)
    );

endmodule

FILE: src/scfb_checker.sv
module scfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_opcode,
    input logic [7:0]  i_data_byte,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_index,
    input logic [15:0] i_cfg_data,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_tx_byte,
    input logic        o_tx_valid,
    input logic [6:0]  o_pin_levels,
    input logic        o_bad_command,
    input logic        o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte) && $stable(o_last))
        else $error("stalled result changed");

    // non-frame results are single, zero-byte results
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_last && o_tx_byte == 8'h00)
        else $error("non-frame result malformed");

    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_command |-> !o_tx_valid)
        else $error("bad command carried a frame byte");

    // frame bytes stream without gaps until the last one
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_tx_valid && !o_last |=> o_valid && o_tx_valid)
        else $error("gap inside a frame");

endmodule

bind servo_command_frame_bridge_core scfb_checker u_scfb_checker (.*);

FILE: sim/tb_top.sv
module tb_top;
    import scfb_pkg::*;

    localparam logic [7:0] CFG_SPARE = 8'd3;     // first index past the register list
    localparam logic [7:0] CFG_TOP   = 8'hFF;

    localparam logic [7:0] HDR_SYNC0    = 8'hFA;
    localparam logic [7:0] HDR_SYNC1    = 8'hAF;
    localparam logic [7:0] ADDR_TORQUE  = 8'h24;
    localparam logic [7:0] ADDR_POS     = 8'h1E;
    localparam logic [7:0] LEN_POS      = 8'h04;
    localparam logic [7:0] TORQUE_ON    = 8'h01;
    localparam logic [7:0] CENTER_POS   = 8'd128;
    localparam logic [15:0] DEG_STEP    = 16'd6;

    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 50;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] data;
    } t_host_cmd;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [6:0] pin_levels;
        logic       bad_command;
        logic       is_last;
    } t_tx_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_opcode = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_cfg_ready;
    logic        o_valid;
    logic [7:0]  o_tx_byte;
    logic        o_tx_valid;
    logic [6:0]  o_pin_levels;
    logic        o_bad_command;
    logic        o_last;

    servo_command_frame_bridge_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tx_byte    (o_tx_byte),
        .o_tx_valid   (o_tx_valid),
        .o_pin_levels (o_pin_levels),
        .o_bad_command(o_bad_command),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's registers and pin state
    logic [15:0] speed_word = 16'd1;
    logic [7:0]  servo_a_ident = 8'd1;
    logic [7:0]  servo_b_ident = 8'd2;
    logic [6:0]  pin_state = 7'd0;

    t_host_cmd  cmd_pending[$];
    t_tx_result frame_expect_q[$];

    int  cmds_issued = 0;
    int  cmds_accepted = 0;
    int  cfg_writes_done = 0;
    int  err_count = 0;
    logic in_taken = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int rx_tick = 0;
    int stall_pct = 0;

    function automatic void predict_command(input logic [7:0] op, input logic [7:0] dat);
        logic [7:0]  frame [FRAME_LEN];
        logic [7:0]  ident;
        logic [7:0]  chk;
        logic [15:0] angle;
        t_tx_result  r;
        int k;
        r.tx_byte = '0;
        r.tx_valid = 1'b0;
        r.bad_command = 1'b0;
        r.is_last = 1'b1;
        if (op == OP_PINS) begin
            pin_state = dat[6:0];
            r.pin_levels = pin_state;
            frame_expect_q.push_back(r);
        end else if (op != OP_SERVO_A && op != OP_SERVO_B) begin
            r.pin_levels = pin_state;
            r.bad_command = 1'b1;
            frame_expect_q.push_back(r);
        end else begin
            ident = (op == OP_SERVO_A) ? servo_a_ident : servo_b_ident;
            angle = ({8'd0, CENTER_POS} - {8'd0, dat}) * DEG_STEP;
            frame[0] = HDR_SYNC0;  frame[1] = HDR_SYNC1;  frame[2] = ident;
            frame[3] = 8'h00;      frame[4] = ADDR_TORQUE; frame[5] = 8'h01;
            frame[6] = 8'h01;      frame[7] = TORQUE_ON;
            frame[9] = HDR_SYNC0;  frame[10] = HDR_SYNC1; frame[11] = ident;
            frame[12] = 8'h00;     frame[13] = ADDR_POS;  frame[14] = LEN_POS;
            frame[15] = 8'h01;
            frame[16] = angle[7:0];
            frame[17] = angle[15:8];
            frame[18] = speed_word[7:0];
            frame[19] = speed_word[15:8];
            // checksum covers id through the byte before the sum
            chk = '0;
            for (k = 2; k < 8; k++) chk ^= frame[k];
            frame[8] = chk;
            chk = '0;
            for (k = 11; k < 20; k++) chk ^= frame[k];
            frame[20] = chk;
            for (k = 0; k < FRAME_LEN; k++) begin
                r.tx_byte = frame[k];
                r.tx_valid = 1'b1;
                r.pin_levels = pin_state;
                r.is_last = (k == FRAME_LEN - 1);
                frame_expect_q.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, fname, want, got);
        end
    endfunction

    // sample all transfers at the rising edge
    always @(posedge i_clk) begin
        t_tx_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                predict_command(i_opcode, i_data_byte);
                cmds_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPEED: speed_word = i_cfg_data;
                    CFG_A_ID:  servo_a_ident = i_cfg_data[7:0];
                    CFG_B_ID:  servo_b_ident = i_cfg_data[7:0];
                    default: ;
                endcase
                cfg_writes_done++;
            end
            if (o_valid && i_ready) begin
                if (frame_expect_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, got byte 0x%0h",
                             $time, o_tx_byte);
                end else begin
                    want = frame_expect_q.pop_front();
                    check_field("tx_byte", want.tx_byte, o_tx_byte);
                    check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, o_tx_valid});
                    check_field("pin_levels", {1'b0, want.pin_levels}, {1'b0, o_pin_levels});
                    check_field("bad_command", {7'd0, want.bad_command}, {7'd0, o_bad_command});
                    check_field("last", {7'd0, want.is_last}, {7'd0, o_last});
                end
            end
        end
    end

    // command driver: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        t_host_cmd item;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (cmd_pending.size() != 0) begin
                item = cmd_pending.pop_front();
                i_valid <= 1'b1;
                i_opcode <= item.opcode;
                i_data_byte <= item.data;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result sink: stall rate re-picked when rx_tick runs out, long hold on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done++;
            hold_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else begin
            if (rx_tick == 0) begin
                rx_tick = 64;
                case ($urandom_range(4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    3: stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            rx_tick--;
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_cmd(input logic [7:0] op, input logic [7:0] dat);
        t_host_cmd item;
        item.opcode = op;
        item.data = dat;
        cmd_pending.push_back(item);
        cmds_issued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmds_accepted != cmds_issued || frame_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        int target;
        target = cfg_writes_done + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(negedge i_clk);
        while (cfg_writes_done != target);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            2: return CENTER_POS;
            3: return CENTER_POS - 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial begin
        int sel;
        logic [7:0] op;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values first
        queue_cmd(OP_SERVO_A, CENTER_POS);
        queue_cmd(OP_SERVO_B, 8'd0);
        queue_cmd(OP_PINS, 8'hFF);          // bit 7 must be dropped
        queue_cmd(OP_SERVO_A, 8'd255);
        queue_cmd(8'h00, 8'h5A);            // unassigned opcodes
        queue_cmd(8'hFF, 8'hA5);
        queue_cmd(8'h02, 8'hFF);
        queue_cmd(8'h06, 8'h00);
        queue_cmd(8'h09, 8'h80);
        queue_cmd(OP_PINS, 8'h00);
        queue_cmd(OP_SERVO_B, 8'd1);
        queue_cmd(OP_PINS, 8'h2A);
        queue_cmd(OP_SERVO_A, CENTER_POS - 8'd1);
        queue_cmd(OP_SERVO_B, CENTER_POS + 8'd1);
        wait_drained();

        write_reg(CFG_SPEED, 16'hFFFF);
        write_reg(CFG_A_ID, 16'h00FF);
        write_reg(CFG_B_ID, 16'hFF00);      // upper byte ignored
        write_reg(CFG_SPARE, 16'h1234);     // no such register
        write_reg(CFG_TOP, 16'hFFFF);
        queue_cmd(OP_SERVO_A, 8'd0);
        queue_cmd(OP_SERVO_B, 8'd255);
        queue_cmd(8'h80, 8'h7F);
        queue_cmd(OP_PINS, 8'h55);
        wait_drained();

        write_reg(CFG_SPEED, 16'h0000);
        write_reg(CFG_A_ID, 16'h0000);
        write_reg(CFG_B_ID, 16'h00FF);
        queue_cmd(OP_SERVO_A, CENTER_POS);
        queue_cmd(OP_SERVO_B, 8'd64);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_reg(CFG_SPEED, pick_reg_value());
            write_reg(CFG_A_ID, pick_reg_value());
            write_reg(CFG_B_ID, pick_reg_value());
            if ($urandom_range(2) == 0)
                write_reg(8'($urandom_range(3, 255)), pick_reg_value());
            // back up the result path while commands keep coming
            if (ph == 2)
                hold_req++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(99);
                if (sel < 38)
                    op = OP_SERVO_A;
                else if (sel < 76)
                    op = OP_SERVO_B;
                else if (sel < 88)
                    op = OP_PINS;
                else
                    op = 8'($urandom_range(255));
                queue_cmd(op, pick_data());
            end
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
